[rtl/core/ffc_pkg.sv]
`default_nettype none
package ffc_pkg;

	localparam int ANG_W        = 34;   // Q4.28 angle plus headroom for a difference
	localparam int Z_W          = 32;   // residual angle inside the rotator
	localparam int XY_W         = 33;   // rotator vector, Q30
	localparam int CS_W         = 32;   // sine / cosine, Q28
	localparam int CORDIC_STEPS = 28;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 3;   // wrap, fold, steps, output
	localparam int POS_W        = 33;   // position difference
	localparam int D_W          = 40;   // lateral offset / arc position before saturation
	localparam int DEN_W        = 58;   // divisor in Q24
	localparam int DVS_W        = 62;   // divisor in Q28
	localparam int NUM_W        = 64;   // speed * cos, Q44

	localparam logic signed [ANG_W-1:0] Q28_PI      = 34'sd843314857;
	localparam logic signed [ANG_W-1:0] Q28_TWO_PI  = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] Q28_HALF_PI = 34'sd421657428;
	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [DEN_W-1:0] ONE_Q24     = 58'sd16777216;
	localparam logic signed [DEN_W-1:0] DEN_FLOOR   = 58'sd167772;

	function automatic logic signed [Z_W-1:0] atan_step(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0: r = 32'sd210828714;
			1: r = 32'sd124459457;
			2: r = 32'sd65760959;
			3: r = 32'sd33381290;
			4: r = 32'sd16755422;
			5: r = 32'sd8385879;
			6: r = 32'sd4193963;
			7: r = 32'sd2097109;
			8: r = 32'sd1048571;
			9: r = 32'sd524287;
			default: r = Z_W'(32'sd1 <<< (28 - i));
		endcase
		return r;
	endfunction

	// saturate to dw signed bits, present in a 32-bit field
	function automatic logic [31:0] sat_field(input logic signed [63:0] v, input int dw);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		logic signed [63:0] r;
		hi = (64'sd1 <<< (dw - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi)
			r = hi;
		else if (v < lo)
			r = lo;
		else
			r = v;
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/ffc_cordic.sv]
`default_nettype none
module ffc_cordic (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [ffc_pkg::ANG_W-1:0]    angle,
	output logic signed [ffc_pkg::CS_W-1:0]          cos_q28,
	output logic signed [ffc_pkg::CS_W-1:0]          sin_q28
);

	localparam int STEPS = ffc_pkg::CORDIC_STEPS;
	localparam logic signed [ffc_pkg::ANG_W-1:0] T1 = ffc_pkg::Q28_PI + ffc_pkg::Q28_TWO_PI;
	localparam logic signed [ffc_pkg::ANG_W-1:0] T2 =
		ffc_pkg::Q28_PI + ffc_pkg::Q28_TWO_PI + ffc_pkg::Q28_TWO_PI;

	logic signed [ffc_pkg::ANG_W-1:0] wrap_d;
	logic signed [ffc_pkg::ANG_W-1:0] wrap_q;
	logic signed [ffc_pkg::ANG_W-1:0] fold_d;
	logic                             fold_neg;
	logic signed [ffc_pkg::Z_W-1:0]   z_q [0:STEPS];
	logic signed [ffc_pkg::XY_W-1:0]  x_q [1:STEPS];
	logic signed [ffc_pkg::XY_W-1:0]  y_q [1:STEPS];
	logic [STEPS:0]                   neg_q;

	// bring into [-pi, pi]: at most three turns, enough for the difference of two 32-bit Q28 angles
	always_comb begin
		if (angle > T2)
			wrap_d = angle - 3 * ffc_pkg::Q28_TWO_PI;
		else if (angle > T1)
			wrap_d = angle - 2 * ffc_pkg::Q28_TWO_PI;
		else if (angle > ffc_pkg::Q28_PI)
			wrap_d = angle - ffc_pkg::Q28_TWO_PI;
		else if (angle < -T2)
			wrap_d = angle + 3 * ffc_pkg::Q28_TWO_PI;
		else if (angle < -T1)
			wrap_d = angle + 2 * ffc_pkg::Q28_TWO_PI;
		else if (angle < -ffc_pkg::Q28_PI)
			wrap_d = angle + ffc_pkg::Q28_TWO_PI;
		else
			wrap_d = angle;
	end

	always_comb begin
		fold_neg = 1'b0;
		fold_d   = wrap_q;
		if (wrap_q > ffc_pkg::Q28_HALF_PI) begin
			fold_d   = ffc_pkg::Q28_PI - wrap_q;
			fold_neg = 1'b1;
		end else if (wrap_q < -ffc_pkg::Q28_HALF_PI) begin
			fold_d   = -ffc_pkg::Q28_PI - wrap_q;
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wrap_q   <= wrap_d;
			z_q[0]   <= ffc_pkg::Z_W'(fold_d);
			neg_q[0] <= fold_neg;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [ffc_pkg::XY_W-1:0] xi;
		logic signed [ffc_pkg::XY_W-1:0] yi;
		if (i == 0) begin : g_first
			assign xi = ffc_pkg::CORDIC_GAIN;
			assign yi = '0;
		end else begin : g_next
			assign xi = x_q[i];
			assign yi = y_q[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_q[i] >= 0) begin
					x_q[i+1] <= xi - (yi >>> i);
					y_q[i+1] <= yi + (xi >>> i);
					z_q[i+1] <= z_q[i] - ffc_pkg::atan_step(i);
				end else begin
					x_q[i+1] <= xi + (yi >>> i);
					y_q[i+1] <= yi - (xi >>> i);
					z_q[i+1] <= z_q[i] + ffc_pkg::atan_step(i);
				end
				neg_q[i+1] <= neg_q[i];
			end
		end
	end

	logic signed [ffc_pkg::XY_W-1:0] xs;
	logic signed [ffc_pkg::XY_W-1:0] ys;
	assign xs = x_q[STEPS] >>> 2;
	assign ys = y_q[STEPS] >>> 2;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q28 <= neg_q[STEPS] ? ffc_pkg::CS_W'(-xs) : ffc_pkg::CS_W'(xs);
			sin_q28 <= ffc_pkg::CS_W'(ys);
		end
	end

endmodule
`default_nettype wire

[rtl/core/ffc_div.sv]
`default_nettype none
module ffc_div #(
	parameter int QB = 32
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [ffc_pkg::NUM_W-1:0]  num,
	input  wire logic [ffc_pkg::DVS_W-1:0]         dvs,
	output logic [31:0]                            quo
);

	localparam int NW = ffc_pkg::NUM_W;
	localparam int DW = ffc_pkg::DVS_W;

	logic [NW-1:0] rem_q [0:QB];
	logic [QB-1:0] q_q   [0:QB];
	logic [DW-1:0] dvs_q [0:QB];
	logic [QB:0]   neg_q;
	logic [QB:0]   ovf_q;
	logic [NW-1:0] mag;

	assign mag = num[NW-1] ? NW'(-num) : NW'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= mag;
			q_q[0]   <= '0;
			dvs_q[0] <= dvs;
			neg_q[0] <= num[NW-1];
			// quotient would need more than QB bits: saturate
			ovf_q[0] <= (NW'(mag >> QB) >= NW'(dvs));
		end
	end

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < QB; k++) begin : g_bit
		localparam int B = QB - 1 - k;
		logic take;
		assign take = NW'(rem_q[k] >> B) >= NW'(dvs_q[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= take ? rem_q[k] - (NW'(dvs_q[k]) << B) : rem_q[k];
				q_q[k+1]   <= take ? (q_q[k] | (QB'(1) << B)) : q_q[k];
				dvs_q[k+1] <= dvs_q[k];
				neg_q[k+1] <= neg_q[k];
				ovf_q[k+1] <= ovf_q[k];
			end
		end
	end

	logic signed [63:0] qv;
	logic signed [63:0] big;
	assign qv  = neg_q[QB] ? -$signed(64'(q_q[QB])) : $signed(64'(q_q[QB]));
	assign big = neg_q[QB] ? -(64'sd1 <<< QB) : (64'sd1 <<< QB);

	always_ff @(posedge clk) begin
		if (en)
			quo <= ffc_pkg::sat_field(ovf_q[QB] ? big : qv, QB);
	end

endmodule
`default_nettype wire

[rtl/core/frenet_frame_conversion_unit.sv]
`default_nettype none
// channel  handshake            payload
// input    in_valid/in_ready    pos_x pos_y heading speed ref_x ref_y ref_heading ref_arc
//                               ref_curvature
// output   out_valid/out_ready  arc_pos arc_speed lat_offset lat_speed divisor_clamped
//
// One transaction per cycle unless the output stalls; the pipeline runs from the input
// register through the two 28-step rotators (one step per stage), stages P1 to P4 and the
// divider (one quotient bit per stage). The last stage is the output register.
// Reset clears only the valid bits. When out_valid is held without out_ready the
// whole pipeline holds and in_ready drops.
module frenet_frame_conversion_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] heading,
	input  wire logic signed [31:0] speed,
	input  wire logic signed [31:0] ref_x,
	input  wire logic signed [31:0] ref_y,
	input  wire logic signed [31:0] ref_heading,
	input  wire logic signed [31:0] ref_arc,
	input  wire logic signed [31:0] ref_curvature,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      arc_pos,
	output logic signed [31:0]      arc_speed,
	output logic signed [31:0]      lat_offset,
	output logic signed [31:0]      lat_speed,
	output logic                    divisor_clamped
);

	localparam int CL    = ffc_pkg::CORDIC_LAT;
	localparam int DL    = DATA_WIDTH + 2;
	localparam int TOTAL = CL + 5 + DL;
	localparam int AW    = ffc_pkg::ANG_W;
	localparam int PW    = ffc_pkg::POS_W;
	localparam int CW    = ffc_pkg::CS_W;
	localparam int DDW   = ffc_pkg::D_W;
	localparam int NW    = ffc_pkg::DEN_W;
	localparam logic signed [ffc_pkg::CS_W-1:0] CS_LIMIT = 32'sd269484032;

	logic             en;
	logic [TOTAL-1:0] vld_q;

	assign en        = !vld_q[TOTAL-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[TOTAL-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TOTAL-2:0], in_valid};
	end

	// stage 1: differences
	logic signed [PW-1:0] dx_s1, dy_s1;
	logic signed [AW-1:0] rth_s1, dth_s1;
	logic signed [31:0]   v_s1, rs_s1, kap_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= PW'(pos_x) - PW'(ref_x);
			dy_s1  <= PW'(pos_y) - PW'(ref_y);
			rth_s1 <= AW'(ref_heading);
			dth_s1 <= AW'(heading) - AW'(ref_heading);
			v_s1   <= speed;
			rs_s1  <= ref_arc;
			kap_s1 <= ref_curvature;
		end
	end

	logic signed [CW-1:0] cr, sr, cd, sd;

	ffc_cordic u_rot_ref (
		.clk     (clk),
		.en      (en),
		.angle   (rth_s1),
		.cos_q28 (cr),
		.sin_q28 (sr)
	);

	ffc_cordic u_rot_dif (
		.clk     (clk),
		.en      (en),
		.angle   (dth_s1),
		.cos_q28 (cd),
		.sin_q28 (sd)
	);

	// side data matched to rotator latency
	logic signed [PW-1:0] dx_q  [0:CL-1];
	logic signed [PW-1:0] dy_q  [0:CL-1];
	logic signed [31:0]   v_q   [0:CL-1];
	logic signed [31:0]   rs_q  [0:CL-1];
	logic signed [31:0]   kap_q [0:CL-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dx_q[0]  <= dx_s1;
			dy_q[0]  <= dy_s1;
			v_q[0]   <= v_s1;
			rs_q[0]  <= rs_s1;
			kap_q[0] <= kap_s1;
			for (int k = 1; k < CL; k++) begin
				dx_q[k]  <= dx_q[k-1];
				dy_q[k]  <= dy_q[k-1];
				v_q[k]   <= v_q[k-1];
				rs_q[k]  <= rs_q[k-1];
				kap_q[k] <= kap_q[k-1];
			end
		end
	end

	// P1: products
	logic signed [64:0] cdy_s2, sdx_s2, cdx_s2, sdy_s2;
	logic signed [63:0] vs_s2, vc_s2;
	logic signed [31:0] rs_s2, kap_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cdy_s2 <= 65'(cr) * 65'(dy_q[CL-1]);
			sdx_s2 <= 65'(sr) * 65'(dx_q[CL-1]);
			cdx_s2 <= 65'(cr) * 65'(dx_q[CL-1]);
			sdy_s2 <= 65'(sr) * 65'(dy_q[CL-1]);
			vs_s2  <= 64'(v_q[CL-1]) * 64'(sd);
			vc_s2  <= 64'(v_q[CL-1]) * 64'(cd);
			rs_s2  <= rs_q[CL-1];
			kap_s2 <= kap_q[CL-1];
		end
	end

	// P2: projections
	logic signed [65:0]  lat_sum, arc_sum;
	logic signed [DDW-1:0] d_s3, s_s3, dd_s3;
	logic signed [63:0]  num_s3;
	logic signed [31:0]  kap_s3;

	assign lat_sum = 66'(cdy_s2) - 66'(sdx_s2);
	assign arc_sum = 66'(cdx_s2) + 66'(sdy_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3   <= DDW'(lat_sum >>> 28);
			s_s3   <= DDW'(rs_s2) + DDW'(arc_sum >>> 28);
			dd_s3  <= DDW'(vs_s2 >>> 28);
			num_s3 <= vc_s2;
			kap_s3 <= kap_s2;
		end
	end

	// P3: curvature times offset, split in high and low parts
	logic signed [DDW-17:0] dh;
	logic signed [16:0]     dl;
	logic signed [55:0]     kph_s4;
	logic signed [48:0]     kpl_s4;
	logic signed [63:0]     num_s4;
	logic [31:0]            arc_s4, lat_s4, ls_s4;

	assign dh = d_s3[DDW-1:16];
	assign dl = {1'b0, d_s3[15:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			kph_s4 <= 56'(kap_s3) * 56'(dh);
			kpl_s4 <= 49'(kap_s3) * 49'(dl);
			num_s4 <= num_s3;
			arc_s4 <= ffc_pkg::sat_field(64'(s_s3), DATA_WIDTH);
			lat_s4 <= ffc_pkg::sat_field(64'(d_s3), DATA_WIDTH);
			ls_s4  <= ffc_pkg::sat_field(64'(dd_s3), DATA_WIDTH);
		end
	end

	// P4: divisor with floor
	logic signed [NW-1:0] den_raw;
	logic signed [NW-1:0] den_s5;
	logic                 clamp_s5;
	logic signed [63:0]   num_s5;
	logic [31:0]          arc_s5, lat_s5, ls_s5;

	assign den_raw = ffc_pkg::ONE_Q24 - (NW'(kph_s4) + NW'(kpl_s4 >>> 16));

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_s5 <= den_raw <= 0;
			den_s5   <= (den_raw <= 0) ? ffc_pkg::DEN_FLOOR : den_raw;
			num_s5   <= num_s4;
			arc_s5   <= arc_s4;
			lat_s5   <= lat_s4;
			ls_s5    <= ls_s4;
		end
	end

	ffc_div #(
		.QB (DATA_WIDTH)
	) u_div (
		.clk (clk),
		.en  (en),
		.num (num_s5),
		.dvs ({den_s5[NW-2:0], 4'b0000, 1'b0} >> 1),
		.quo (arc_speed)
	);

	// side data matched to divider latency
	logic [31:0] arc_q [0:DL-1];
	logic [31:0] lat_q [0:DL-1];
	logic [31:0] ls_q  [0:DL-1];
	logic [DL-1:0] clamp_q;

	always_ff @(posedge clk) begin
		if (en) begin
			arc_q[0]   <= arc_s5;
			lat_q[0]   <= lat_s5;
			ls_q[0]    <= ls_s5;
			clamp_q[0] <= clamp_s5;
			for (int k = 1; k < DL; k++) begin
				arc_q[k]   <= arc_q[k-1];
				lat_q[k]   <= lat_q[k-1];
				ls_q[k]    <= ls_q[k-1];
				clamp_q[k] <= clamp_q[k-1];
			end
		end
	end

	assign arc_pos         = arc_q[DL-1];
	assign lat_offset      = lat_q[DL-1];
	assign lat_speed       = ls_q[DL-1];
	assign divisor_clamped = clamp_q[DL-1];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during a stall");

	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[CL+4] |-> den_s5 > 0)
		else $error("divisor not positive after floor");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[CL] |-> (cr <= CS_LIMIT && cr >= -CS_LIMIT && cd <= CS_LIMIT && cd >= -CS_LIMIT))
		else $error("rotator cosine out of range");

endmodule
`default_nettype wire
